### hdl/bfa_pkg.sv
package bfa_pkg;

	// Width of one bitmap word and of the counters.
	localparam int WORD_BITS = 64;
	localparam int COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes carried by an input item.
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_RESERVE = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_OOM    = 2'd1,
		ST_REJECT = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic check;
		logic scan;
		logic clear;
		logic load_out;
	} bfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_alloc;
		logic word_full;
		logic scan_last;
		logic clear_last;
	} bfa_stat_t;

endpackage

### hdl/bfa_ram.sv
module bfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hdl/bfa_dp.sv
module bfa_dp import bfa_pkg::*; #(
	parameter int FRAME_COUNT = 65536,
	localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS,
	localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfa_cmd_t             cmd,
	output bfa_stat_t            stat,
	input  logic [1:0]           operation,
	input  logic [19:0]          frame_number,
	output logic [1:0]           status,
	output logic [15:0]          granted_frame,
	output logic [COUNT_W-1:0]   free_count,
	output logic [COUNT_W-1:0]   total_count,
	output logic                 ram_wr_en,
	output logic [WORD_W-1:0]    ram_wr_addr,
	output logic [WORD_BITS-1:0] ram_wr_data,
	output logic                 ram_rd_en,
	output logic [WORD_W-1:0]    ram_rd_addr,
	input  logic [WORD_BITS-1:0] ram_rd_data
);

	localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
	localparam logic [20:0] FRAME_LIMIT = 21'(FRAME_COUNT);

	op_t                  op_q;
	logic [19:0]          frame_q;
	logic [WORD_W-1:0]    hint_q;
	logic [WORD_W-1:0]    scan_addr_q;
	logic [WORD_W-1:0]    scan_left_q;
	logic [WORD_W-1:0]    clr_addr_q;
	logic [COUNT_W-1:0]   free_q;
	logic [COUNT_W-1:0]   total_q;
	status_t              res_status_q;
	logic [15:0]          res_granted_q;

	logic [13:0]          req_word;
	logic [13:0]          item_word;
	logic [WORD_W-1:0]    req_addr;
	logic [WORD_W-1:0]    item_addr;
	logic [WORD_W-1:0]    scan_next;
	logic [WORD_BITS-1:0] word_inc;
	logic [WORD_BITS-1:0] zero_onehot;
	logic [WORD_BITS-1:0] word_alloc;
	logic [5:0]           zero_idx;
	logic [25:0]          alloc_frame;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 bit_used;
	logic                 out_of_range;
	logic                 word_full;

	// Check-stage decisions.
	logic                 chk_write;
	logic [WORD_BITS-1:0] chk_word;
	logic [COUNT_W-1:0]   chk_free;
	logic [COUNT_W-1:0]   chk_total;
	status_t              chk_status;

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
	endfunction

	function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
		return (c == '0) ? '0 : c - COUNT_W'(1);
	endfunction

	// Word addresses of the incoming and the held frame.
	assign req_word  = frame_number[19:6];
	assign item_word = frame_q[19:6];
	assign req_addr  = req_word[WORD_W-1:0];
	assign item_addr = item_word[WORD_W-1:0];
	assign scan_next = (scan_addr_q == LAST_WORD) ? '0 : scan_addr_q + WORD_W'(1);

	// Lowest free bit of the word under scan: adding one sets it.
	assign word_full   = (ram_rd_data == '1);
	assign word_inc    = ram_rd_data + WORD_BITS'(1);
	assign zero_onehot = ~ram_rd_data & word_inc;
	assign word_alloc  = ram_rd_data | word_inc;

	always_comb begin
		zero_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (zero_onehot[i]) begin
				zero_idx = zero_idx | 6'(i);
			end
		end
	end

	assign alloc_frame = 26'({scan_addr_q, zero_idx});

	// Single-frame operations on the word read for the held item.
	assign bit_mask     = WORD_BITS'(1) << frame_q[5:0];
	assign bit_used     = ram_rd_data[frame_q[5:0]];
	assign out_of_range = ({1'b0, frame_q} >= FRAME_LIMIT);

	always_comb begin
		chk_write  = 1'b0;
		chk_word   = ram_rd_data;
		chk_free   = free_q;
		chk_total  = total_q;
		chk_status = ST_OK;
		if (out_of_range) begin
			chk_status = ST_REJECT;
		end else begin
			unique case (op_q)
				OP_FREE: begin
					if (frame_q == '0) begin
						chk_status = ST_REJECT;
					end else if (!bit_used) begin
						chk_status = ST_DOUBLE;
					end else begin
						chk_write = 1'b1;
						chk_word  = ram_rd_data & ~bit_mask;
						chk_free  = count_up(free_q);
					end
				end
				OP_RELEASE: begin
					if (bit_used) begin
						chk_write = 1'b1;
						chk_word  = ram_rd_data & ~bit_mask;
						chk_free  = count_up(free_q);
						chk_total = count_up(total_q);
					end
				end
				OP_RESERVE: begin
					if (!bit_used) begin
						chk_write = 1'b1;
						chk_word  = ram_rd_data | bit_mask;
						chk_free  = count_down(free_q);
					end
				end
				default: begin
					chk_status = ST_REJECT;
				end
			endcase
		end
	end

	// Memory port control.
	always_comb begin
		ram_rd_en   = cmd.accept | (cmd.scan & word_full & ~stat.scan_last);
		ram_rd_addr = cmd.accept ? ((op_t'(operation) == OP_ALLOC) ? hint_q : req_addr)
		                         : scan_next;
		ram_wr_en   = cmd.clear | (cmd.check & chk_write) | (cmd.scan & ~word_full);
		ram_wr_data = '1;
		ram_wr_addr = clr_addr_q;
		if (cmd.check) begin
			ram_wr_data = chk_word;
			ram_wr_addr = item_addr;
		end else if (cmd.scan) begin
			ram_wr_data = word_alloc;
			ram_wr_addr = scan_addr_q;
		end
	end

	// Status toward the controller.
	assign stat.req_alloc  = (op_t'(operation) == OP_ALLOC);
	assign stat.word_full  = word_full;
	assign stat.scan_last  = (scan_left_q == '0);
	assign stat.clear_last = (clr_addr_q == LAST_WORD);

	// Item registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op_t'(operation);
			frame_q <= frame_number;
		end
	end

	// Control and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q        <= '0;
			scan_addr_q   <= '0;
			scan_left_q   <= '0;
			clr_addr_q    <= '0;
			free_q        <= '0;
			total_q       <= '0;
			res_status_q  <= ST_OK;
			res_granted_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + WORD_W'(1);
			end
			if (cmd.accept) begin
				scan_addr_q <= hint_q;
				scan_left_q <= LAST_WORD;
			end
			if (cmd.check) begin
				free_q        <= chk_free;
				total_q       <= chk_total;
				res_status_q  <= chk_status;
				res_granted_q <= '0;
			end
			if (cmd.scan) begin
				if (!word_full) begin
					hint_q        <= scan_addr_q;
					free_q        <= count_down(free_q);
					res_status_q  <= ST_OK;
					res_granted_q <= alloc_frame[15:0];
				end else if (stat.scan_last) begin
					res_status_q  <= ST_OOM;
					res_granted_q <= '0;
				end else begin
					scan_addr_q <= scan_next;
					scan_left_q <= scan_left_q - WORD_W'(1);
				end
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status        <= res_status_q;
			granted_frame <= res_granted_q;
			free_count    <= free_q;
			total_count   <= total_q;
		end
	end

endmodule

### hdl/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  bfa_stat_t stat,
	output bfa_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = ~rsp_valid_q | rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.req_alloc ? S_SCAN : S_CHECK;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (!stat.word_full || stat.scan_last) begin
					state_d = S_RESP;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/bitmap_frame_allocator.sv
// Channel   Handshake             Payload
// request   req_valid/req_ready   operation, frame_number
// response  rsp_valid/rsp_ready   status, granted_frame, free_count, total_count
//
// Free, release and reserve hold the block through accept, check and result load.
// Alloc holds it through accept, a scan of N bitmap words (1 to ceil(FRAME_COUNT/64)) and result load,
// as the bitmap memory's single read port delivers one word a cycle.
// After reset, a clearing pass writes every bitmap word before any item.
// A new item is accepted while a result waits; work stalls only when a second result
// is ready to load.
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int FRAME_COUNT = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         operation,
	input  logic [19:0]        frame_number,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [1:0]         status,
	output logic [15:0]        granted_frame,
	output logic [COUNT_W-1:0] free_count,
	output logic [COUNT_W-1:0] total_count
);

	localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	bfa_cmd_t             cmd;
	bfa_stat_t            stat;
	logic                 ram_wr_en;
	logic [WORD_W-1:0]    ram_wr_addr;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [WORD_W-1:0]    ram_rd_addr;
	logic [WORD_BITS-1:0] ram_rd_data;

	// Sequencer.
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Counters, search pointer and bit operations.
	bfa_dp #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.frame_number  (frame_number),
		.status        (status),
		.granted_frame (granted_frame),
		.free_count    (free_count),
		.total_count   (total_count),
		.ram_wr_en     (ram_wr_en),
		.ram_wr_addr   (ram_wr_addr),
		.ram_wr_data   (ram_wr_data),
		.ram_rd_en     (ram_rd_en),
		.ram_rd_addr   (ram_rd_addr),
		.ram_rd_data   (ram_rd_data)
	);

	// Used/free bitmap, one bit per frame.
	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bfa_pkg::*;

	localparam int FRAMES = 65536;
	localparam int MAP_WORDS = FRAMES / WORD_BITS;
	// Most traffic lands in a small group of frames so that allocs, frees and
	// double frees meet each other often.
	localparam int HOT_FRAMES = 512;
	localparam int RANDOM_ITEMS = 1550;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		op_t         op;
		logic [19:0] frame;
		bit          wait_idle;
	} frame_req_t;

	typedef struct {
		status_t            status;
		logic [15:0]        granted;
		logic [COUNT_W-1:0] free_cnt;
		logic [COUNT_W-1:0] total_cnt;
	} frame_rsp_t;

	typedef enum {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [1:0]         operation = OP_ALLOC;
	logic [19:0]        frame_number = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [1:0]         status;
	logic [15:0]        granted_frame;
	logic [COUNT_W-1:0] free_count;
	logic [COUNT_W-1:0] total_count;

	// Our own copy of the allocator state.
	logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
	logic [COUNT_W-1:0]   model_free_cnt;
	logic [COUNT_W-1:0]   usable_frames;
	int                   hint_word;

	frame_req_t req_queue[$];
	frame_rsp_t owed_results[$];
	frame_req_t next_req;

	int unsigned sent_items = 0;
	int unsigned taken_items = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	bit          long_hold_done = 1'b0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          errors = 0;

	bitmap_frame_allocator #(
		.FRAME_COUNT(FRAMES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.frame_number(frame_number),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.granted_frame(granted_frame),
		.free_count(free_count),
		.total_count(total_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the allocator copy and return the result it yields.
	function automatic frame_rsp_t apply_frame_op(op_t op, logic [19:0] frame);
		frame_rsp_t r;
		int w;
		int b;
		bit found;
		r.status = ST_OK;
		r.granted = '0;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			// Next-fit: scan words from the hint with wrap, take the lowest free bit.
			for (int i = 0; i < MAP_WORDS && !found; i++) begin
				w = (hint_word + i) % MAP_WORDS;
				if (frame_map[w] != '1) begin
					b = 0;
					while (b < WORD_BITS - 1 && frame_map[w][b])
						b++;
					if (w * WORD_BITS + b < FRAMES) begin
						frame_map[w][b] = 1'b1;
						model_free_cnt = (model_free_cnt == 0) ? model_free_cnt :
							model_free_cnt - 1'b1;
						hint_word = w;
						r.granted = 16'(w * WORD_BITS + b);
						found = 1'b1;
					end
				end
			end
			if (!found)
				r.status = ST_OOM;
		end else if (frame >= FRAMES) begin
			r.status = ST_REJECT;
		end else if (op == OP_FREE) begin
			if (frame == 0) begin
				r.status = ST_REJECT;
			end else if (!frame_map[frame[15:6]][frame[5:0]]) begin
				r.status = ST_DOUBLE;
			end else begin
				frame_map[frame[15:6]][frame[5:0]] = 1'b0;
				model_free_cnt = (model_free_cnt == COUNT_MAX) ? model_free_cnt :
					model_free_cnt + 1'b1;
			end
		end else if (op == OP_RELEASE) begin
			// A frame already free is not counted twice.
			if (frame_map[frame[15:6]][frame[5:0]]) begin
				frame_map[frame[15:6]][frame[5:0]] = 1'b0;
				usable_frames = (usable_frames == COUNT_MAX) ? usable_frames :
					usable_frames + 1'b1;
				model_free_cnt = (model_free_cnt == COUNT_MAX) ? model_free_cnt :
					model_free_cnt + 1'b1;
			end
		end else begin
			if (!frame_map[frame[15:6]][frame[5:0]]) begin
				frame_map[frame[15:6]][frame[5:0]] = 1'b1;
				model_free_cnt = (model_free_cnt == 0) ? model_free_cnt :
					model_free_cnt - 1'b1;
			end
		end
		r.free_cnt = model_free_cnt;
		r.total_cnt = usable_frames;
		return r;
	endfunction

	function automatic void push_req(op_t op, logic [19:0] frame, bit wait_idle);
		frame_req_t q;
		q.op = op;
		q.frame = frame;
		q.wait_idle = wait_idle;
		req_queue.push_back(q);
	endfunction

	// Mostly the hot group, sometimes anywhere in the map, sometimes any 20-bit value.
	function automatic logic [19:0] pick_frame();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 20'($urandom_range(0, HOT_FRAMES - 1));
		else if (r < 90)
			return 20'($urandom_range(0, FRAMES - 1));
		else
			return 20'($urandom);
	endfunction

	// Start-up is release heavy, the middle is mixed and the tail drains the pool.
	function automatic op_t pick_op(int k);
		int unsigned r;
		int alloc_th;
		int free_th;
		int release_th;
		r = $urandom_range(0, 99);
		if (k < 200) begin
			alloc_th = 15;
			free_th = 30;
			release_th = 90;
		end else if (k >= RANDOM_ITEMS - 250) begin
			alloc_th = 85;
			free_th = 90;
			release_th = 95;
		end else begin
			alloc_th = 35;
			free_th = 60;
			release_th = 85;
		end
		if (r < alloc_th)
			return OP_ALLOC;
		else if (r < free_th)
			return OP_FREE;
		else if (r < release_th)
			return OP_RELEASE;
		else
			return OP_RESERVE;
	endfunction

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Request driver: bursts of items with random gaps, holding each item until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (sent_items != taken_items) begin
			// The current item is still waiting for the block.
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			req_valid <= 1'b0;
		end else if (req_queue.size() == 0 ||
				(req_queue[0].wait_idle && owed_results.size() != 0)) begin
			req_valid <= 1'b0;
		end else begin
			next_req = req_queue.pop_front();
			req_valid <= 1'b1;
			operation <= next_req.op;
			frame_number <= next_req.frame;
			sent_items <= sent_items + 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// Response receiver: random stall patterns plus one long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && results_seen >= 300) begin
			rsp_ready <= 1'b0;
			hold_left <= 400;
			long_hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(16, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN: begin
					rsp_ready <= 1'b1;
				end
				RX_LIGHT: begin
					rsp_ready <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					rsp_ready <= ($urandom_range(0, 9) < 3);
				end
			endcase
		end
	end

	// Monitor: check each result, then record the item taken at this edge.
	always @(posedge clk) begin
		frame_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen <= results_seen + 1;
			if (owed_results.size() == 0) begin
				$error("result arrived with no item outstanding");
				errors++;
			end else begin
				want = owed_results.pop_front();
				compare_field("status", want.status, status);
				compare_field("granted_frame", want.granted, granted_frame);
				compare_field("free_count", want.free_cnt, free_count);
				compare_field("total_count", want.total_cnt, total_count);
			end
		end
		if (arst_n && req_valid && req_ready) begin
			owed_results.push_back(apply_frame_op(op_t'(operation), frame_number));
			taken_items <= taken_items + 1;
		end
	end

	initial begin
		op_t op;
		bit  pause;
		for (int i = 0; i < MAP_WORDS; i++)
			frame_map[i] = '1;
		model_free_cnt = '0;
		usable_frames = '0;
		hint_word = 0;

		// Directed: empty map, rejected frames, repeats, double frees and hint wrap.
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_FREE, 20'd0, 1'b0);
		push_req(OP_FREE, 20'd65536, 1'b0);
		push_req(OP_RELEASE, 20'hFFFFF, 1'b0);
		push_req(OP_RESERVE, 20'd65536, 1'b0);
		push_req(OP_RELEASE, 20'd0, 1'b0);
		push_req(OP_RELEASE, 20'd65535, 1'b0);
		push_req(OP_RELEASE, 20'd1, 1'b0);
		push_req(OP_RELEASE, 20'd1, 1'b0);
		push_req(OP_FREE, 20'd1, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_FREE, 20'd65535, 1'b0);
		push_req(OP_FREE, 20'd65535, 1'b0);
		push_req(OP_RESERVE, 20'd65535, 1'b0);
		push_req(OP_RESERVE, 20'd65535, 1'b0);
		push_req(OP_RELEASE, 20'd63, 1'b0);
		push_req(OP_RELEASE, 20'd64, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_ALLOC, 20'd0, 1'b0);
		push_req(OP_FREE, 20'hFFFFF, 1'b0);
		push_req(OP_ALLOC, 20'hFFFFF, 1'b0);
		push_req(OP_FREE, 20'd64, 1'b0);

		// Random traffic; twice the sender waits for every result before going on.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			op = pick_op(k);
			pause = (k == 500 || k == 1100);
			push_req(op, pick_frame(), pause);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || sent_items != taken_items)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && owed_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// Hang guard, well beyond a run where every alloc scans the whole map.
	initial begin
		#100_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

### sim.f
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_dp.sv
hdl/bfa_ctrl.sv
hdl/bitmap_frame_allocator.sv
dv/tb_top.sv
